// ===== design/bmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

    // One heap entry as held in the store
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] primary;
        logic [15:0] secondary;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Command transfer payload
    typedef struct packed {
        logic        action;
        logic [15:0] entry_id;
        logic [15:0] primary_key;
        logic [15:0] secondary_key;
    } cmd_t;

    // Result transfer payload
    typedef struct packed {
        logic [15:0] out_id;
        logic [15:0] out_primary;
        logic [15:0] out_secondary;
        logic [1:0]  status;
        logic [10:0] occupancy;
    } res_t;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_RM_ROOT,
        ST_RM_LAST,
        ST_RM_MOVE,
        ST_DN_L,
        ST_DN_LD,
        ST_DN_RD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/binary_min_heap_two_key.sv =====
// A refused command goes straight to the result; an insert climbs one level per parent
// compare, and a remove descends level by level, weighing the left and then the right
// child, all through the single store read port and comparator. A new command is taken
// only once the previous result has been handed to the output register.
// Reset clears the entry count and control state; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_two_key #(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire bmh_pkg::cmd_t   cmd,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output bmh_pkg::res_t        res
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    bmh_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            res_valid_reg, res_valid_next;
    logic [CW-1:0]   last_reg, last_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   best_idx_reg, best_idx_next;
    bmh_pkg::entry_t mov_reg, mov_next;
    bmh_pkg::entry_t best_reg, best_next;
    bmh_pkg::entry_t out_entry_reg, out_entry_next;
    logic [1:0]      status_reg, status_next;
    bmh_pkg::res_t   res_reg, res_next;

    logic            we;
    logic [CW-1:0]   waddr;
    bmh_pkg::entry_t wdata;
    logic [CW-1:0]   raddr;
    bmh_pkg::entry_t rdata;
    bmh_pkg::entry_t cmp_a, cmp_b;
    logic            less;
    logic [IW-1:0]   left_idx, right_idx, last_ext;

    bmh_ram #(
        .WIDTH (bmh_pkg::ENTRY_W),
        .DEPTH (HEAP_DEPTH + 1)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    bmh_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .less (less)
    );

    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = {pos_reg, 1'b1};
    assign last_ext  = IW'(last_reg);

    assign cmd_stall = (state_reg != bmh_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequence the sift steps
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && res_stall;
        last_next      = last_reg;
        pos_next       = pos_reg;
        best_idx_next  = best_idx_reg;
        mov_next       = mov_reg;
        best_next      = best_reg;
        out_entry_next = out_entry_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = mov_reg;
        raddr          = ONE_C;
        cmp_a          = rdata;
        cmp_b          = mov_reg;

        case (state_reg)
            bmh_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    out_entry_next = '0;
                    status_next    = bmh_pkg::STATUS_OK;
                    mov_next       = '{id: cmd.entry_id, primary: cmd.primary_key,
                                       secondary: cmd.secondary_key};
                    if (cmd.action == bmh_pkg::ACT_INSERT)
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            status_next = bmh_pkg::STATUS_FULL;
                            state_next  = bmh_pkg::ST_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + ONE_C;
                            pos_next   = count_reg + ONE_C;
                            state_next = bmh_pkg::ST_UP_CHK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = bmh_pkg::STATUS_EMPTY;
                        state_next  = bmh_pkg::ST_DONE;
                    end
                    else
                    begin
                        last_next  = count_reg;
                        state_next = bmh_pkg::ST_RM_ROOT;
                    end
                end
            end

            // Climb: fetch the parent, or settle at the root
            bmh_pkg::ST_UP_CHK:
            begin
                if (pos_reg == ONE_C)
                begin
                    we         = 1'b1;
                    state_next = bmh_pkg::ST_DONE;
                end
                else
                begin
                    raddr      = pos_reg >> 1;
                    state_next = bmh_pkg::ST_UP_CMP;
                end
            end

            // Move the parent down into the hole, or drop the new entry here
            bmh_pkg::ST_UP_CMP:
            begin
                cmp_a = mov_reg;
                cmp_b = rdata;
                we    = 1'b1;
                if (less)
                begin
                    wdata      = rdata;
                    pos_next   = pos_reg >> 1;
                    state_next = bmh_pkg::ST_UP_CHK;
                end
                else
                begin
                    state_next = bmh_pkg::ST_DONE;
                end
            end

            bmh_pkg::ST_RM_ROOT:
            begin
                raddr      = ONE_C;
                state_next = bmh_pkg::ST_RM_LAST;
            end

            // Capture the old root, fetch the last entry
            bmh_pkg::ST_RM_LAST:
            begin
                raddr          = last_reg;
                out_entry_next = rdata;
                state_next     = bmh_pkg::ST_RM_MOVE;
            end

            bmh_pkg::ST_RM_MOVE:
            begin
                mov_next   = rdata;
                count_next = count_reg - ONE_C;
                pos_next   = ONE_C;
                if (last_reg == ONE_C)
                begin
                    state_next = bmh_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bmh_pkg::ST_DN_L;
                end
            end

            // Descend: fetch the left child, or settle when there is none
            bmh_pkg::ST_DN_L:
            begin
                if (left_idx >= last_ext)
                begin
                    we         = 1'b1;
                    state_next = bmh_pkg::ST_DONE;
                end
                else
                begin
                    raddr      = left_idx[CW-1:0];
                    state_next = bmh_pkg::ST_DN_LD;
                end
            end

            // Weigh the left child against the moving entry
            bmh_pkg::ST_DN_LD:
            begin
                cmp_a = rdata;
                cmp_b = mov_reg;
                if (right_idx < last_ext)
                begin
                    raddr = right_idx[CW-1:0];
                    if (less)
                    begin
                        best_next     = rdata;
                        best_idx_next = left_idx[CW-1:0];
                    end
                    else
                    begin
                        best_next     = mov_reg;
                        best_idx_next = pos_reg;
                    end
                    state_next = bmh_pkg::ST_DN_RD;
                end
                else
                begin
                    we = 1'b1;
                    if (less)
                    begin
                        wdata      = rdata;
                        pos_next   = left_idx[CW-1:0];
                        state_next = bmh_pkg::ST_DN_L;
                    end
                    else
                    begin
                        state_next = bmh_pkg::ST_DONE;
                    end
                end
            end

            // Weigh the right child against the best so far and advance
            bmh_pkg::ST_DN_RD:
            begin
                cmp_a = rdata;
                cmp_b = best_reg;
                we    = 1'b1;
                if (less)
                begin
                    wdata      = rdata;
                    pos_next   = right_idx[CW-1:0];
                    state_next = bmh_pkg::ST_DN_L;
                end
                else if (best_idx_reg != pos_reg)
                begin
                    wdata      = best_reg;
                    pos_next   = best_idx_reg;
                    state_next = bmh_pkg::ST_DN_L;
                end
                else
                begin
                    state_next = bmh_pkg::ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            bmh_pkg::ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{out_id: out_entry_reg.id,
                                 out_primary: out_entry_reg.primary,
                                 out_secondary: out_entry_reg.secondary,
                                 status: status_reg,
                                 occupancy: 11'(count_reg)};
                    state_next = bmh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bmh_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmh_pkg::ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold working and result payload
    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        pos_reg       <= pos_next;
        best_idx_reg  <= best_idx_next;
        mov_reg       <= mov_next;
        best_reg      <= best_next;
        out_entry_reg <= out_entry_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

// ===== design/bmh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/bmh_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmh_cmp (
    input  wire bmh_pkg::entry_t a,
    input  wire bmh_pkg::entry_t b,
    output logic                 less
);

    // Order by primary key, then by secondary key; strict
    always_comb
    begin
        if (a.primary != b.primary)
        begin
            less = (a.primary < b.primary);
        end
        else
        begin
            less = (a.secondary < b.secondary);
        end
    end

endmodule

`default_nettype wire

// ===== verif/binary_min_heap_two_key_test.sv =====
`timescale 1ns / 1ps

module binary_min_heap_two_key_test;

    localparam int HEAP_DEPTH   = 1024;
    localparam int CMD_TARGET   = 1450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    bmh_pkg::cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    bmh_pkg::res_t res;

    binary_min_heap_two_key #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Commands waiting to be offered, and results owed by the block
    bmh_pkg::cmd_t pending_cmds[$];
    bmh_pkg::res_t due_results[$];
    int unsigned total_cmds = 0;
    int unsigned cmds_sent  = 0;
    int unsigned fails      = 0;
    int unsigned gen_fill   = 0;

    // Heap mirror: slots 1..heap_fill are live
    bmh_pkg::entry_t heap_mem [1:HEAP_DEPTH];
    int unsigned heap_fill = 0;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    // Order by primary key, then by secondary key
    function automatic bit entry_precedes(bmh_pkg::entry_t a, bmh_pkg::entry_t b);
        if (a.primary != b.primary)
            return a.primary < b.primary;
        return a.secondary < b.secondary;
    endfunction

    function automatic void swap_slots(int unsigned i, int unsigned j);
        bmh_pkg::entry_t tmp;
        tmp         = heap_mem[i];
        heap_mem[i] = heap_mem[j];
        heap_mem[j] = tmp;
    endfunction

    // Apply one command to the mirror and return the result it owes
    function automatic bmh_pkg::res_t heap_apply(bmh_pkg::cmd_t c);
        bmh_pkg::res_t r;
        int unsigned   pos;
        int unsigned   best;
        int unsigned   kid;
        int unsigned   last;
        bit            moving;
        r        = '0;
        r.status = bmh_pkg::STATUS_OK;
        if (c.action == bmh_pkg::ACT_INSERT)
        begin
            if (heap_fill >= HEAP_DEPTH)
            begin
                r.status = bmh_pkg::STATUS_FULL;
            end
            else
            begin
                heap_fill++;
                pos = heap_fill;
                heap_mem[pos] = '{id: c.entry_id, primary: c.primary_key,
                                  secondary: c.secondary_key};
                // sift up while strictly smaller than the parent
                while (pos > 1 && entry_precedes(heap_mem[pos], heap_mem[pos >> 1]))
                begin
                    swap_slots(pos, pos >> 1);
                    pos = pos >> 1;
                end
            end
        end
        else if (heap_fill == 0)
        begin
            r.status = bmh_pkg::STATUS_EMPTY;
        end
        else
        begin
            last = heap_fill;
            swap_slots(1, last);
            pos    = 1;
            moving = 1'b1;
            // sift down among the slots below last, left child first, strict moves only
            while (moving)
            begin
                best = pos;
                kid  = pos << 1;
                if (kid < last && entry_precedes(heap_mem[kid], heap_mem[best]))
                    best = kid;
                if (kid + 1 < last && entry_precedes(heap_mem[kid + 1], heap_mem[best]))
                    best = kid + 1;
                if (best == pos)
                begin
                    moving = 1'b0;
                end
                else
                begin
                    swap_slots(best, pos);
                    pos = best;
                end
            end
            r.out_id        = heap_mem[last].id;
            r.out_primary   = heap_mem[last].primary;
            r.out_secondary = heap_mem[last].secondary;
            heap_fill--;
        end
        r.occupancy = 11'(heap_fill);
        return r;
    endfunction

    function automatic bmh_pkg::cmd_t make_cmd(logic act, logic [15:0] id,
                                               logic [15:0] pk, logic [15:0] sk);
        bmh_pkg::cmd_t c;
        c.action        = act;
        c.entry_id      = id;
        c.primary_key   = pk;
        c.secondary_key = sk;
        return c;
    endfunction

    // Keys half the time from a narrow range so that ties are common
    function automatic logic [15:0] rand_key();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 3));
    endfunction

    // Queue one random command; keep a count of the heap for shaping
    task automatic queue_random(int unsigned insert_pct);
        logic act;
        act = ($urandom_range(0, 99) < insert_pct) ? bmh_pkg::ACT_INSERT
                                                   : bmh_pkg::ACT_REMOVE;
        pending_cmds.push_back(make_cmd(act, 16'($urandom()), rand_key(), rand_key()));
        if (act == bmh_pkg::ACT_INSERT)
        begin
            if (gen_fill < HEAP_DEPTH)
                gen_fill++;
        end
        else if (gen_fill != 0)
        begin
            gen_fill--;
        end
    endtask

    // Clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #20_000_000;
        $display("binary_min_heap_two_key_test: done, errors");
        $finish;
    end

    // Idle mix by progress: sender light and receiver heavy, then swapped, then none
    always_comb
    begin
        if (cmds_sent * 3 < total_cmds)
        begin
            send_idle_pct = 8;
            recv_idle_pct = 81;
        end
        else if (cmds_sent * 3 < total_cmds * 2)
        begin
            send_idle_pct = 81;
            recv_idle_pct = 8;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Build the command list, reset, then wait for the block to drain
    initial
    begin
        // remove from empty, then extremes and ties
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'h0000, 16'h0000, 16'h0000));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'h1234, 16'h0005, 16'h0009));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'h1235, 16'h0005, 16'h0003));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'h1236, 16'h0005, 16'h0003));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'hAAAA, 16'h0005, 16'h0003));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'h5555, 16'h0000, 16'hFFFF));
        pending_cmds.push_back(make_cmd(bmh_pkg::ACT_INSERT, 16'h8001, 16'hFFFF, 16'h0000));
        repeat (9)
            pending_cmds.push_back(make_cmd(bmh_pkg::ACT_REMOVE, 16'h0000, 16'h0000,
                                            16'h0000));

        // mixed traffic around a small heap, touching empty now and then
        repeat (250)
            queue_random(55);
        // fill to capacity, then try a few inserts that must be refused
        while (gen_fill < HEAP_DEPTH)
            queue_random(100);
        repeat (4)
            queue_random(100);
        // mostly removes from a deep heap
        while (pending_cmds.size() < CMD_TARGET)
            queue_random(30);
        total_cmds = pending_cmds.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("binary_min_heap_two_key_test: done, clean");
        else
            $display("binary_min_heap_two_key_test: done, errors");
        $finish;
    end

    // Command driver: predict on each transfer, offer the next command with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            cmds_sent <= 0;
        end
        else
        begin : drive_blk
            logic taken;
            taken = cmd_valid && !cmd_stall;
            if (taken)
            begin
                due_results.push_back(heap_apply(cmd));
                void'(pending_cmds.pop_front());
                cmds_sent <= cmds_sent + 1;
            end
            // hold the payload while stalled
            if (!cmd_valid || taken)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_cmds[0];
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: one long hold-off early on, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (!hold_done && cmds_sent >= 40)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            fails++;
        end
    endtask

    // Result monitor: compare each transfer with the oldest owed result
    always @(posedge clk)
    begin : monitor_blk
        bmh_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: result with none owed, expected nothing, actual %h", $time, res);
                fails++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("out_id", want.out_id, res.out_id);
                check_field("out_primary", want.out_primary, res.out_primary);
                check_field("out_secondary", want.out_secondary, res.out_secondary);
                check_field("status", 16'(want.status), 16'(res.status));
                check_field("occupancy", 16'(want.occupancy), 16'(res.occupancy));
            end
        end
    end

endmodule
